// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the encoder checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property that is disabled while reset is asserted.
`define CBE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked property that also holds across reset.
`define CBE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/cbe_pkg.sv =====
// ----------------------------------------------------------------------------
// CBOR encoder package
// Types, codes and constants shared by the encoder modules.
// ----------------------------------------------------------------------------
package cbe_pkg;

    localparam int unsigned MAX_BYTES_DEF = 65535;
    localparam logic [15:0] CAP_RESET     = 16'd1024;
    localparam int unsigned JOB_BYTES     = 9;

    localparam logic [7:0] AI_ONE_BYTE  = 8'h18;
    localparam logic [7:0] AI_TWO_BYTE  = 8'h19;
    localparam logic [7:0] BSTR_EIGHT   = 8'h48;
    localparam logic [63:0] IMM_LIMIT   = 64'd24;

    typedef enum logic [2:0] {
        KIND_HEAD    = 3'd0,
        KIND_SIGNED  = 3'd1,
        KIND_UINT64  = 3'd2,
        KIND_PAYLOAD = 3'd3,
        KIND_RESTART = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_TOO_LARGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OP_BYTES,
        OP_TOO_LARGE,
        OP_RESTART,
        OP_NONE
    } t_op;

    typedef struct packed {
        t_op                          op;
        logic [JOB_BYTES-1:0][7:0]    bytes;
        logic [3:0]                   count;
        logic                         block;
    } t_job;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [15:0] out_index;
        logic        byte_valid;
        t_status     status;
        logic        last;
        logic [15:0] used_size;
    } t_result;

endpackage

// ===== rtl/core/cbor_head_and_item_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// CBOR head and item encoder
// Streaming encoder of CBOR heads, integers, uint64 byte strings, payload and restarts.
// ----------------------------------------------------------------------------
// Input words are written with push while full is low. Each word carries a
// kind and its operands. Results are read with pop while empty is low; each
// result is one written byte with its buffer position, or one status word
// without a byte, and o_last marks the final result of an input word.
// The capacity register is written on the configuration channel, which is
// always ready; it should only change while the encoder is idle.
// A front end decodes each word into a byte job in a two-entry job queue.
// A back end writes one byte per cycle while the result queue has room,
// against the running position, into a two-entry result queue. A word is
// registered in the job queue, the back end and the result queue in turn.
// Throughput is one result per cycle while pop is high. A word gives one
// result per byte, one to three for heads and nine for a uint64; an error
// result ends it early. Reset clears the write position, both queues and
// sets the capacity to 1024. When pop stays low the result queue fills,
// the back end holds, and full rises once the job queue holds two words.
// ----------------------------------------------------------------------------
module cbor_head_and_item_encoder_unit #(
    parameter int unsigned MAX_BYTES = cbe_pkg::MAX_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         i_kind,
    input  logic [2:0]         i_major_type,
    input  logic [63:0]        i_argument,
    input  logic signed [31:0] i_signed_value,
    input  logic [7:0]         i_payload_byte,
    input  logic               pop,
    output logic               empty,
    output logic [7:0]         o_out_byte,
    output logic [15:0]        o_out_index,
    output logic               o_byte_valid,
    output logic [1:0]         o_status,
    output logic               o_last,
    output logic [15:0]        o_used_size,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data
);

    localparam logic [15:0] MaxBytes16 = 16'(MAX_BYTES);

    logic [15:0]      r_capacity;
    logic [15:0]      capacity;
    logic             job_valid;
    logic             job_pop;
    cbe_pkg::t_job    job;
    logic             res_full;
    logic             res_push;
    cbe_pkg::t_result res_in;
    cbe_pkg::t_result res_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= cbe_pkg::CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_capacity <= i_cfg_data;
        end
    end

    assign capacity = (r_capacity > MaxBytes16) ? MaxBytes16 : r_capacity;

    cbe_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_kind         (i_kind),
        .i_major_type   (i_major_type),
        .i_argument     (i_argument),
        .i_signed_value (i_signed_value),
        .i_payload_byte (i_payload_byte),
        .i_job_pop      (job_pop),
        .o_job_valid    (job_valid),
        .o_job          (job)
    );

    cbe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_capacity  (capacity),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    cbe_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (res_out)
    );

    assign o_out_byte   = res_out.out_byte;
    assign o_out_index  = res_out.out_index;
    assign o_byte_valid = res_out.byte_valid;
    assign o_status     = res_out.status;
    assign o_last       = res_out.last;
    assign o_used_size  = res_out.used_size;

endmodule

// ===== rtl/core/cbe_front.sv =====
// ----------------------------------------------------------------------------
// CBOR encoder front end
// Accepts input words, turns each into a byte job and holds two jobs.
// ----------------------------------------------------------------------------
module cbe_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [2:0]          i_kind,
    input  logic [2:0]          i_major_type,
    input  logic [63:0]         i_argument,
    input  logic signed [31:0]  i_signed_value,
    input  logic [7:0]          i_payload_byte,
    input  logic                i_job_pop,
    output logic                o_job_valid,
    output cbe_pkg::t_job       o_job
);

    cbe_pkg::t_job r_q [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    cbe_pkg::t_job job;
    logic [63:0]   value;
    logic [7:0]    top;
    logic          do_push;
    logic          do_pop;

    always_comb begin
        if (cbe_pkg::t_kind'(i_kind) == cbe_pkg::KIND_SIGNED) begin
            value = i_signed_value[31] ? {32'd0, ~i_signed_value} : {32'd0, i_signed_value};
            top   = {2'b00, i_signed_value[31], 5'd0};
        end else begin
            value = i_argument;
            top   = {i_major_type, 5'd0};
        end

        job       = '0;
        job.op    = cbe_pkg::OP_NONE;
        unique case (cbe_pkg::t_kind'(i_kind))
            cbe_pkg::KIND_HEAD, cbe_pkg::KIND_SIGNED: begin
                job.op = cbe_pkg::OP_BYTES;
                if (value < cbe_pkg::IMM_LIMIT) begin
                    job.bytes[0] = top | value[7:0];
                    job.count    = 4'd1;
                end else if (value[63:8] == '0) begin
                    job.bytes[0] = top | cbe_pkg::AI_ONE_BYTE;
                    job.bytes[1] = value[7:0];
                    job.count    = 4'd2;
                end else if (value[63:16] == '0) begin
                    job.bytes[0] = top | cbe_pkg::AI_TWO_BYTE;
                    job.bytes[1] = value[15:8];
                    job.bytes[2] = value[7:0];
                    job.count    = 4'd3;
                    job.block    = 1'b1;
                end else begin
                    job.op = cbe_pkg::OP_TOO_LARGE;
                end
            end
            cbe_pkg::KIND_UINT64: begin
                job.op       = cbe_pkg::OP_BYTES;
                job.bytes[0] = cbe_pkg::BSTR_EIGHT;
                for (int i = 0; i < 8; i++) begin
                    job.bytes[i+1] = i_argument[63-8*i -: 8];
                end
                job.count = 4'd9;
                job.block = 1'b1;
            end
            cbe_pkg::KIND_PAYLOAD: begin
                job.op       = cbe_pkg::OP_BYTES;
                job.bytes[0] = i_payload_byte;
                job.count    = 4'd1;
            end
            cbe_pkg::KIND_RESTART: begin
                job.op = cbe_pkg::OP_RESTART;
            end
            default: begin
                job.op = cbe_pkg::OP_NONE;
            end
        endcase
    end

    assign full        = (r_count == 2'd2);
    assign o_job_valid = (r_count != 2'd0);
    assign o_job       = r_q[r_rd_ptr];
    assign do_push     = push && !full;
    assign do_pop      = i_job_pop && o_job_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr_ptr] <= job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

// ===== rtl/core/cbe_back.sv =====
// ----------------------------------------------------------------------------
// CBOR encoder back end
// Writes one byte of the current job per step, checks capacity, keeps the position.
// ----------------------------------------------------------------------------
module cbe_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [15:0]       i_capacity,
    input  logic              i_job_valid,
    input  cbe_pkg::t_job     i_job,
    output logic              o_job_pop,
    input  logic              i_res_full,
    output logic              o_res_push,
    output cbe_pkg::t_result  o_res
);

    cbe_pkg::t_job r_job;
    logic          r_busy;
    logic [3:0]    r_idx;
    logic [15:0]   r_pos;
    logic [15:0]   n_pos;
    logic [3:0]    n_idx;
    logic          n_busy;
    logic          step;
    logic          done;
    logic          ok;
    logic          in_block;
    logic          is_last;
    logic [16:0]   block_end;

    always_comb begin
        step      = r_busy && !i_res_full;
        in_block  = r_job.block && (r_idx != 4'd0);
        is_last   = (r_idx == r_job.count - 4'd1);
        block_end = {1'b0, r_pos} + 17'(r_job.count) - 17'd1;
        if (!in_block) begin
            ok = (r_pos < i_capacity);
        end else if (r_idx == 4'd1) begin
            ok = (block_end <= {1'b0, i_capacity});
        end else begin
            ok = 1'b1;
        end

        n_pos           = r_pos;
        o_res           = '0;
        o_res.status    = cbe_pkg::ST_OK;
        o_res.last      = 1'b1;
        o_res.used_size = r_pos;
        done            = 1'b1;
        unique case (r_job.op)
            cbe_pkg::OP_BYTES: begin
                if (ok) begin
                    o_res.out_byte   = r_job.bytes[r_idx];
                    o_res.out_index  = r_pos;
                    o_res.byte_valid = 1'b1;
                    o_res.last       = is_last;
                    o_res.used_size  = r_pos + 16'd1;
                    n_pos            = r_pos + 16'd1;
                    done             = is_last;
                end else begin
                    o_res.status = cbe_pkg::ST_OVERFLOW;
                end
            end
            cbe_pkg::OP_TOO_LARGE: begin
                o_res.status = cbe_pkg::ST_TOO_LARGE;
            end
            cbe_pkg::OP_RESTART: begin
                o_res.used_size = 16'd0;
                n_pos           = 16'd0;
            end
            default: begin
                o_res.used_size = r_pos;
            end
        endcase
        if (!step) begin
            n_pos = r_pos;
        end

        o_res_push = step;
        o_job_pop  = i_job_valid && (!r_busy || (step && done));
        if (o_job_pop) begin
            n_busy = 1'b1;
            n_idx  = 4'd0;
        end else if (step && done) begin
            n_busy = 1'b0;
            n_idx  = r_idx;
        end else if (step) begin
            n_busy = r_busy;
            n_idx  = r_idx + 4'd1;
        end else begin
            n_busy = r_busy;
            n_idx  = r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 4'd0;
            r_pos  <= 16'd0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
            r_pos  <= n_pos;
        end
    end

endmodule

// ===== rtl/core/cbe_res_fifo.sv =====
// ----------------------------------------------------------------------------
// CBOR encoder result queue
// Two-entry queue that parts the byte writer from the result consumer.
// ----------------------------------------------------------------------------
module cbe_res_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cbe_pkg::t_result  i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output cbe_pkg::t_result  o_data
);

    cbe_pkg::t_result r_q [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_q[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

// ===== rtl/core/cbe_checker.sv =====
// ----------------------------------------------------------------------------
// CBOR encoder port checker
// Properties on the result channel of the encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cbe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        pop,
    input logic        empty,
    input logic [7:0]  o_out_byte,
    input logic [15:0] o_out_index,
    input logic        o_byte_valid,
    input logic [1:0]  o_status,
    input logic        o_last,
    input logic [15:0] o_used_size
);

    `CBE_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> empty, "result queue not empty after reset")

    `CBE_ASSERT(a_byte_ok, i_clk, i_rst_n, (!empty && o_byte_valid) |-> (o_status == cbe_pkg::ST_OK), "written byte carries an error status")

    `CBE_ASSERT(a_error_last, i_clk, i_rst_n, (!empty && o_status != cbe_pkg::ST_OK) |-> (o_last && !o_byte_valid), "error word is not a final word without a byte")

    `CBE_ASSERT(a_used_follows, i_clk, i_rst_n, (!empty && o_byte_valid) |-> (o_used_size == o_out_index + 16'd1), "used size does not follow the byte position")

    `CBE_ASSERT(a_hold, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_out_byte)), "stalled result word changed")

endmodule

bind cbor_head_and_item_encoder_unit cbe_checker u_cbe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .pop          (pop),
    .empty        (empty),
    .o_out_byte   (o_out_byte),
    .o_out_index  (o_out_index),
    .o_byte_valid (o_byte_valid),
    .o_status     (o_status),
    .o_last       (o_last),
    .o_used_size  (o_used_size)
);
